// ===== rtl/mau_pkg.sv =====
// Package: shared types, constants and command structs for the modular arithmetic unit.
package mau_pkg;

	localparam int unsigned MOD_W     = 31;
	localparam int unsigned OPB_W     = 63;
	localparam int unsigned ACT_W     = 3;
	localparam int unsigned EXP_BITS_DEF = 63;
	localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

	localparam logic [ACT_W-1:0] ACT_ADD = 3'd0;
	localparam logic [ACT_W-1:0] ACT_SUB = 3'd1;
	localparam logic [ACT_W-1:0] ACT_MUL = 3'd2;
	localparam logic [ACT_W-1:0] ACT_POW = 3'd3;
	localparam logic [ACT_W-1:0] ACT_DIV = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RED_A,
		ST_RED_B,
		ST_DISPATCH,
		ST_POW,
		ST_EUC,
		ST_INV_FIX,
		ST_MUL,
		ST_OUT
	} mau_state_t;

	// Datapath commands, one-hot where more than one could apply.
	typedef struct packed {
		logic load;       // capture the input transaction
		logic red_start;  // start a serial reduction
		logic red_sel_b;  // reduce operand b (else operand a)
		logic addsub;     // compute add or subtract result
		logic mul_start;  // start a modular multiply of a with b or with the inverse
		logic pow_start;  // prepare power loop
		logic pow_step;   // start the next power-loop product when the multiplier is idle
		logic euc_start;  // prepare Euclid
		logic euc_step;   // one Euclid step
		logic inv_fix;    // finish inverse
		logic zero_res;   // force zero result
		logic out_load;   // move result to output register
	} mau_cmd_t;

	typedef struct packed {
		logic red_done;
		logic mul_done;
		logic pow_last;
		logic euc_done;
		logic gcd_one;
		logic mod_small;
		logic [ACT_W-1:0] act;
	} mau_sts_t;

endpackage

// ===== rtl/mau_datapath.sv =====
// Datapath: serial reducer, shift-add modular multiplier, power and Euclid registers.
module mau_datapath import mau_pkg::*; #(
	parameter int unsigned EXP_BITS = EXP_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mau_cmd_t             cmd,
	output mau_sts_t             sts,
	input  logic [MOD_W-1:0]     modulus,
	input  logic [ACT_W-1:0]     in_act,
	input  logic [MOD_W-1:0]     in_a,
	input  logic [OPB_W-1:0]     in_b,
	output logic [MOD_W-1:0]     res_q
);

	localparam int unsigned RCNT_W = $clog2(OPB_W + 1);
	localparam int unsigned ECNT_W = $clog2(EXP_BITS + 1);
	localparam int unsigned SW = MOD_W + 2;

	logic [ACT_W-1:0] act_q;
	logic [MOD_W-1:0] a_q;
	logic [OPB_W-1:0] b_q;
	logic [MOD_W-1:0] bred_q;

	// Bit-serial remainder: shifts the dividend in from the top, one bit a cycle.
	logic [OPB_W-1:0] rsh_q;
	logic [MOD_W:0]   rrem_q;
	logic [RCNT_W-1:0] rcnt_q;
	logic             rbusy_q;
	logic             rsel_b_q;
	logic [MOD_W+1:0] rtry;
	logic [MOD_W:0]   rnext;

	assign rtry  = {rrem_q, rsh_q[OPB_W-1]};
	assign rnext = (rtry >= {2'b0, modulus}) ? rtry[MOD_W:0] - {1'b0, modulus}
	                                         : rtry[MOD_W:0];

	// Shift-add multiplier: mx_q * my_q mod modulus, one multiplier bit a cycle.
	logic [MOD_W-1:0] acc_q;
	logic [MOD_W-1:0] mx_q;
	logic [MOD_W-1:0] my_q;
	logic [MOD_W-1:0] mp_q;
	logic [$clog2(MOD_W+1)-1:0] mcnt_q;
	logic             mbusy_q;
	logic [SW-1:0]    dbl;
	logic [SW-1:0]    dbl_r;
	logic [SW-1:0]    sum;
	logic [SW-1:0]    sum_r;

	assign dbl   = {1'b0, mp_q, 1'b0};
	assign dbl_r = (dbl >= {2'b0, modulus}) ? dbl - {2'b0, modulus} : dbl;
	assign sum   = dbl_r + {2'b0, mx_q};
	assign sum_r = (sum >= {2'b0, modulus}) ? sum - {2'b0, modulus} : sum;

	// Power state.
	logic [MOD_W-1:0] base_q;
	logic [OPB_W-1:0] exp_q;
	logic [ECNT_W-1:0] ecnt_q;
	logic             pphase_q;

	// Euclid state: signed coefficients do not exceed the modulus in magnitude.
	logic [MOD_W-1:0] r0_q, r1_q;
	logic signed [MOD_W+1:0] t0_q, t1_q;
	logic [MOD_W-1:0] qd_q;
	logic [MOD_W-1:0] qrem_q;
	logic [MOD_W-1:0] qsh_q;
	logic [$clog2(MOD_W+1)-1:0] qcnt_q;
	logic             qbusy_q;
	logic [MOD_W:0]   qtry;
	logic             qge;
	logic             euc_done_q;

	assign qtry = {qrem_q, qsh_q[MOD_W-1]};
	assign qge  = qtry >= {1'b0, r1_q};

	logic signed [2*MOD_W+3:0] qt_prod;
	assign qt_prod = $signed({1'b0, qd_q}) * t1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rbusy_q    <= 1'b0;
			mbusy_q    <= 1'b0;
			qbusy_q    <= 1'b0;
			euc_done_q <= 1'b0;
			rcnt_q     <= '0;
			mcnt_q     <= '0;
			qcnt_q     <= '0;
		end else begin
			if (cmd.red_start) begin
				rbusy_q  <= 1'b1;
				rcnt_q   <= cmd.red_sel_b ? RCNT_W'(OPB_W) : RCNT_W'(MOD_W);
				rrem_q   <= '0;
				rsel_b_q <= cmd.red_sel_b;
				rsh_q    <= cmd.red_sel_b ? b_q : {{(OPB_W-MOD_W){1'b0}}, a_q} << (OPB_W-MOD_W);
			end else if (rbusy_q) begin
				rrem_q <= rnext;
				rsh_q  <= rsh_q << 1;
				rcnt_q <= rcnt_q - 1'b1;
				if (rcnt_q == RCNT_W'(1)) begin
					rbusy_q <= 1'b0;
					if (rsel_b_q)
						bred_q <= rnext[MOD_W-1:0];
					else
						a_q <= rnext[MOD_W-1:0];
				end
			end

			if (cmd.load) begin
				act_q <= in_act;
				a_q   <= in_a;
				b_q   <= in_b;
			end

			if (cmd.addsub) begin
				if (act_q == ACT_ADD)
					res_q <= (({1'b0, a_q} + {1'b0, bred_q}) >= {1'b0, modulus})
						? MOD_W'({1'b0, a_q} + {1'b0, bred_q} - {1'b0, modulus})
						: MOD_W'({1'b0, a_q} + {1'b0, bred_q});
				else
					res_q <= (a_q >= bred_q) ? a_q - bred_q
						: MOD_W'({1'b0, a_q} + {1'b0, modulus} - {1'b0, bred_q});
			end
			if (cmd.zero_res)
				res_q <= '0;

			// Multiplier: ACT_MUL uses a*b, divide uses a*inverse.
			if (cmd.mul_start) begin
				mbusy_q <= 1'b1;
				mx_q    <= a_q;
				my_q    <= (act_q == ACT_MUL) ? bred_q : MOD_W'(t0_q);
				mp_q    <= '0;
				mcnt_q  <= $bits(mcnt_q)'(MOD_W);
			end else if (cmd.pow_start) begin
				acc_q    <= (modulus == MOD_W'(1)) ? '0 : MOD_W'(1);
				base_q   <= a_q;
				exp_q    <= b_q;
				ecnt_q   <= ECNT_W'(EXP_BITS);
				pphase_q <= 1'b0;
			end else if (cmd.pow_step && !mbusy_q) begin
				// Phase 0: acc*=base if bit set; phase 1: base*=base.
				mbusy_q <= 1'b1;
				mp_q    <= '0;
				mcnt_q  <= $bits(mcnt_q)'(MOD_W);
				if (!pphase_q) begin
					mx_q  <= exp_q[0] ? acc_q : '0;
					my_q  <= base_q;
				end else begin
					mx_q  <= base_q;
					my_q  <= base_q;
				end
			end else if (mbusy_q) begin
				mp_q   <= my_q[MOD_W-1] ? sum_r[MOD_W-1:0] : dbl_r[MOD_W-1:0];
				my_q   <= my_q << 1;
				mcnt_q <= mcnt_q - 1'b1;
				if (mcnt_q == $bits(mcnt_q)'(1)) begin
					mbusy_q <= 1'b0;
					if (act_q != ACT_POW)
						res_q <= my_q[MOD_W-1] ? sum_r[MOD_W-1:0] : dbl_r[MOD_W-1:0];
					else if (!pphase_q) begin
						if (exp_q[0])
							acc_q <= my_q[MOD_W-1] ? sum_r[MOD_W-1:0] : dbl_r[MOD_W-1:0];
						pphase_q <= 1'b1;
					end else begin
						base_q   <= my_q[MOD_W-1] ? sum_r[MOD_W-1:0] : dbl_r[MOD_W-1:0];
						pphase_q <= 1'b0;
						exp_q    <= exp_q >> 1;
						ecnt_q   <= ecnt_q - 1'b1;
						if (ecnt_q == ECNT_W'(1))
							res_q <= acc_q;
					end
				end
			end

			// Euclid: quotient by a serial divider, then one coefficient update.
			if (cmd.euc_start) begin
				r0_q       <= modulus;
				r1_q       <= bred_q;
				t0_q       <= '0;
				t1_q       <= (MOD_W+2)'(1);
				euc_done_q <= (bred_q == '0);
				qbusy_q    <= 1'b0;
			end else if (cmd.euc_step && !euc_done_q) begin
				if (!qbusy_q) begin
					qbusy_q <= 1'b1;
					qsh_q   <= r0_q;
					qrem_q  <= '0;
					qd_q    <= '0;
					qcnt_q  <= $bits(qcnt_q)'(MOD_W);
				end else if (qcnt_q != '0) begin
					qrem_q <= qge ? MOD_W'(qtry - {1'b0, r1_q}) : qtry[MOD_W-1:0];
					qd_q   <= {qd_q[MOD_W-2:0], qge};
					qsh_q  <= qsh_q << 1;
					qcnt_q <= qcnt_q - 1'b1;
				end else begin
					qbusy_q <= 1'b0;
					r0_q    <= r1_q;
					r1_q    <= qrem_q;
					t0_q    <= t1_q;
					t1_q    <= t0_q - (MOD_W+2)'(qt_prod);
					if (qrem_q == '0)
						euc_done_q <= 1'b1;
				end
			end
			if (cmd.inv_fix && t0_q < 0)
				t0_q <= t0_q + $signed({2'b0, modulus});
		end
	end

	assign sts.red_done  = !rbusy_q;
	assign sts.mul_done  = !mbusy_q;
	assign sts.pow_last  = (ecnt_q == '0);
	assign sts.euc_done  = euc_done_q;
	assign sts.gcd_one   = (r0_q == MOD_W'(1));
	assign sts.mod_small = (modulus < MOD_W'(2));
	assign sts.act       = act_q;

endmodule

// ===== rtl/mau_ctrl.sv =====
// Controller: sequences reduction, operation and output for one transaction.
module mau_ctrl import mau_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_fire,
	input  logic     out_busy,
	input  mau_sts_t sts,
	output mau_cmd_t cmd,
	output logic     busy,
	output logic     err_set
);

	mau_state_t state_q, state_d;
	logic       started_q, started_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			started_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			started_q <= started_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		started_d = started_q;
		cmd       = '0;
		err_set   = 1'b0;
		busy      = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					cmd.load  = 1'b1;
					state_d   = ST_RED_A;
					started_d = 1'b0;
				end
			end
			ST_RED_A: begin
				if (sts.mod_small) begin
					cmd.zero_res = 1'b1;
					state_d      = ST_OUT;
				end else if (!started_q) begin
					cmd.red_start = 1'b1;
					started_d     = 1'b1;
				end else if (sts.red_done) begin
					started_d = 1'b0;
					state_d   = ST_RED_B;
				end
			end
			ST_RED_B: begin
				if (!started_q) begin
					cmd.red_start = 1'b1;
					cmd.red_sel_b = 1'b1;
					started_d     = 1'b1;
				end else if (sts.red_done) begin
					started_d = 1'b0;
					state_d   = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (sts.act)
					ACT_ADD, ACT_SUB: begin
						cmd.addsub = 1'b1;
						state_d    = ST_OUT;
					end
					ACT_MUL: begin
						cmd.mul_start = 1'b1;
						state_d       = ST_MUL;
					end
					ACT_POW: begin
						cmd.pow_start = 1'b1;
						state_d       = ST_POW;
					end
					ACT_DIV: begin
						cmd.euc_start = 1'b1;
						state_d       = ST_EUC;
					end
					default: begin
						cmd.zero_res = 1'b1;
						state_d      = ST_OUT;
					end
				endcase
			end
			ST_POW: begin
				if (sts.pow_last && sts.mul_done)
					state_d = ST_OUT;
				else
					cmd.pow_step = 1'b1;
			end
			ST_EUC: begin
				if (sts.euc_done) begin
					if (sts.gcd_one) begin
						cmd.inv_fix = 1'b1;
						state_d     = ST_INV_FIX;
					end else begin
						cmd.zero_res = 1'b1;
						err_set      = 1'b1;
						state_d      = ST_OUT;
					end
				end else
					cmd.euc_step = 1'b1;
			end
			ST_INV_FIX: begin
				cmd.mul_start = 1'b1;
				state_d       = ST_MUL;
			end
			ST_MUL: begin
				if (sts.mul_done)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/modular_arithmetic_unit.sv =====
// Top level: modular add, subtract, multiply, power and divide.
//
//  channel   dir  handshake        content
//  s_axis    in   tvalid/tready    tdata: action, operand_a, operand_b
//  m_axis    out  tvalid/tready    tdata: result; tuser: error
//  cfg       in   cfg_we           modulus
//
// Power time is set by the bit-serial modular multiplier, two products per
// exponent bit. Divide runs Euclid with a bit-serial quotient. A finished
// result sits in the output register while the next transaction is taken;
// a second result waits in the datapath result register, with the controller
// held in its output state, until the receiver takes the first one. Reset is
// asynchronous and needs no clearing pass.
module modular_arithmetic_unit import mau_pkg::*; #(
	parameter int unsigned EXP_BITS = EXP_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [103:0] s_axis_tdata,  // action[2:0], operand_a[33:3], operand_b[96:34]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [31:0]  m_axis_tdata,  // result[30:0]
	output logic         m_axis_tuser,  // error
	input  logic         cfg_we,
	input  logic [30:0]  cfg_wdata
);

	logic [MOD_W-1:0] modulus_q;
	logic [MOD_W-1:0] res;
	logic             err_q;
	logic             busy;
	logic             err_set;
	logic             ovalid_q;
	logic [MOD_W-1:0] ores_q;
	logic             oerr_q;
	logic [OPB_W-1:0] opb;
	mau_cmd_t         cmd;
	mau_sts_t         sts;

	// The power loop consumes only the low EXP_BITS exponent bits.
	assign opb = s_axis_tdata[96:34];

	assign s_axis_tready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET;
			ovalid_q  <= 1'b0;
			err_q     <= 1'b0;
		end else begin
			if (cfg_we)
				modulus_q <= cfg_wdata;
			if (cmd.load)
				err_q <= 1'b0;
			if (err_set)
				err_q <= 1'b1;
			if (cmd.out_load) begin
				ovalid_q <= 1'b1;
				ores_q   <= res;
				oerr_q   <= err_q || err_set;
			end else if (m_axis_tvalid && m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	mau_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (s_axis_tvalid && s_axis_tready),
		.out_busy (ovalid_q && !m_axis_tready),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy),
		.err_set  (err_set)
	);

	mau_datapath #(.EXP_BITS(EXP_BITS)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.modulus (modulus_q),
		.in_act  (s_axis_tdata[2:0]),
		.in_a    (s_axis_tdata[33:3]),
		.in_b    (opb),
		.res_q   (res)
	);

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {1'b0, ores_q};
	assign m_axis_tuser  = oerr_q;

endmodule

// ===== rtl/mau_checker.sv =====
// Checker: port-level properties of the modular arithmetic unit, bound to the top level.
module mau_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second transaction taken while busy");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0)
		else $error("error result not zero");

	a_top_bit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[31])
		else $error("pad bit set");

endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
